>>> hw/rtl/dsac_pkg.sv
package dsac_pkg;

  // Configuration register indexes, at byte address 8 * index.
  localparam int unsigned RegIdxW = 3;
  localparam logic [RegIdxW-1:0] REG_SIG1_ADDRS   = 3'd0;
  localparam logic [RegIdxW-1:0] REG_SIG2_ADDRS   = 3'd1;
  localparam logic [RegIdxW-1:0] REG_MODE_ADDRS   = 3'd2;
  localparam logic [RegIdxW-1:0] REG_DAY_LEVEL    = 3'd3;
  localparam logic [RegIdxW-1:0] REG_NIGHT_LEVEL  = 3'd4;
  localparam logic [RegIdxW-1:0] REG_BLANK_SECS   = 3'd5;

  localparam int unsigned AddrW = 6;
  localparam int unsigned DataW = 64;

  // Reset values.
  localparam logic [7:0]  DAY_LEVEL_RST    = 8'd255;
  localparam logic [7:0]  NIGHT_LEVEL_RST  = 8'd64;
  localparam logic [7:0]  BLANK_SECS_RST   = 8'd2;
  localparam logic [15:0] LAST_CMD_RST     = 16'hFFFF;
  localparam logic [7:0]  ELAPSED_MAX      = 8'hFF;

  // Signal aspects, in the order of the address slots.
  typedef enum logic [1:0] {
    ASP_VR0 = 2'd0,
    ASP_VR1 = 2'd1,
    ASP_VR2 = 2'd2,
    ASP_OFF = 2'd3
  } aspect_t;

  // Aspect of one signal; pending means it is still blank.
  typedef struct packed {
    aspect_t aspect;
    logic    pending;
  } aspect_state_t;

  // Configuration as seen by the engine.
  typedef struct packed {
    logic [63:0] sig1_addrs;
    logic [63:0] sig2_addrs;
    logic [31:0] mode_addrs;
    logic [7:0]  day_level;
    logic [7:0]  night_level;
    logic [7:0]  blank_secs;
  } dsac_cfg_t;

  // Input item.
  typedef struct packed {
    logic        func;
    logic [15:0] cmd;
  } req_t;

  // Result item.
  typedef struct packed {
    logic [7:0] out1_level;
    logic [7:0] out2_level;
    logic [7:0] out3_level;
    logic [7:0] out4_level;
    logic [7:0] out5_level;
    logic [7:0] out6_level;
    logic [7:0] out7_level;
    logic [7:0] out8_level;
    logic       cmd_matched;
  } rsp_t;

endpackage

>>> hw/rtl/dual_distant_signal_aspect_controller_core.sv
// Controller for two distant signals driving eight LED levels.
// Input channel req (req_valid, req_stall, req): each transfer carries either a
// command address (func 0) or a one-second tick (func 1). Result channel rsp
// (rsp_valid, rsp_stall, rsp): one transfer per input item, in order, with
// all eight LED levels and the command match flag.
// An item is held in the input register, then is evaluated in a single
// pass and lands in the result register, from which the result is offered.
// One item per cycle is sustained while the receiver does not stall; the
// rate is set by the input and result registers.
// While the receiver stalls, the result register holds its item, the input
// register fills, and then req_stall rises until the result is taken.
// The APB port (8-byte register spacing, 64-bit data, always ready) sets the
// addresses, levels and blanking delay; write it only while the block is idle.
// Synchronous reset empties both registers, shows VR0 on both signals in day
// mode, clears the elapsed counts, treats 0xFFFF as the previous command and
// loads the register defaults.
module dual_distant_signal_aspect_controller_core
  import dsac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             req_valid,
  output logic             req_stall,
  input  req_t             req,
  output logic             rsp_valid,
  input  logic             rsp_stall,
  output rsp_t             rsp,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  dsac_cfg_t cfg;
  req_t      in_item;
  logic      in_valid;
  logic      advance;
  logic      accept;
  rsp_t      result;

  dsac_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  dsac_engine u_engine (
    .clk    (clk),
    .rst    (rst),
    .fire   (advance),
    .item   (in_item),
    .cfg    (cfg),
    .result (result)
  );

  // Handshake: the held item moves on when the result slot is free or emptying.
  assign advance   = in_valid && (!rsp_valid || !rsp_stall);
  assign req_stall = in_valid && !advance;
  assign accept    = req_valid && !req_stall;

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (accept) begin
      in_valid <= 1'b1;
    end else if (advance) begin
      in_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_item <= req;
    end
  end

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

>>> hw/rtl/dsac_regs.sv
module dsac_regs
  import dsac_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output dsac_cfg_t        cfg
);

  logic               wr_en;
  logic [RegIdxW-1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[AddrW-1:AddrW-RegIdxW];

  // Register writes; indexes past the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sig1_addrs   <= '0;
      cfg.sig2_addrs   <= '0;
      cfg.mode_addrs   <= '0;
      cfg.day_level    <= DAY_LEVEL_RST;
      cfg.night_level  <= NIGHT_LEVEL_RST;
      cfg.blank_secs   <= BLANK_SECS_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_SIG1_ADDRS:   cfg.sig1_addrs   <= pwdata;
        REG_SIG2_ADDRS:   cfg.sig2_addrs   <= pwdata;
        REG_MODE_ADDRS:   cfg.mode_addrs   <= pwdata[31:0];
        REG_DAY_LEVEL:    cfg.day_level    <= pwdata[7:0];
        REG_NIGHT_LEVEL:  cfg.night_level  <= pwdata[7:0];
        REG_BLANK_SECS:   cfg.blank_secs   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read back.
  always_comb begin
    unique case (reg_idx)
      REG_SIG1_ADDRS:   prdata = cfg.sig1_addrs;
      REG_SIG2_ADDRS:   prdata = cfg.sig2_addrs;
      REG_MODE_ADDRS:   prdata = {32'd0, cfg.mode_addrs};
      REG_DAY_LEVEL:    prdata = {56'd0, cfg.day_level};
      REG_NIGHT_LEVEL:  prdata = {56'd0, cfg.night_level};
      REG_BLANK_SECS:   prdata = {56'd0, cfg.blank_secs};
      default:          prdata = '0;
    endcase
  end

endmodule

>>> hw/rtl/dsac_engine.sv
module dsac_engine
  import dsac_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      fire,
  input  req_t      item,
  input  dsac_cfg_t cfg,
  output rsp_t      result
);

  aspect_state_t aspect_state      [2];
  aspect_state_t aspect_state_next [2];
  logic [7:0]    elapsed           [2];
  logic [7:0]    elapsed_next      [2];
  logic [15:0]   last_command;
  logic [15:0]   last_command_next;
  logic          night_mode;
  logic          night_mode_next;

  logic [15:0]   slot_addr [8];
  logic          hit;
  logic [2:0]    hit_slot;
  logic          matched;
  logic [7:0]    lvl;
  logic [7:0]    leds [2][4];

  // Address slots: signal one VR0..OFF, then signal two VR0..OFF.
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      slot_addr[k]     = cfg.sig1_addrs[k*16 +: 16];
      slot_addr[k + 4] = cfg.sig2_addrs[k*16 +: 16];
    end
  end

  // First matching aspect slot.
  always_comb begin
    hit      = 1'b0;
    hit_slot = '0;
    for (int k = 0; k < 8; k++) begin
      if (!hit && item.cmd == slot_addr[k]) begin
        hit      = 1'b1;
        hit_slot = 3'(k);
      end
    end
  end

  // Next state for one item, then the delay check, then the LED levels.
  always_comb begin
    aspect_state_next = aspect_state;
    elapsed_next      = elapsed;
    last_command_next = last_command;
    night_mode_next   = night_mode;
    matched           = 1'b0;

    if (item.func) begin
      for (int s = 0; s < 2; s++) begin
        if (elapsed[s] != ELAPSED_MAX) begin
          elapsed_next[s] = elapsed[s] + 8'd1;
        end
      end
    end else if (item.cmd != last_command) begin
      last_command_next = item.cmd;
      if (item.cmd == cfg.mode_addrs[15:0]) begin
        night_mode_next = 1'b0;
        matched         = 1'b1;
      end else if (item.cmd == cfg.mode_addrs[31:16]) begin
        night_mode_next = 1'b1;
        matched         = 1'b1;
      end else if (hit) begin
        matched = 1'b1;
        if (aspect_state[hit_slot[2]].aspect != aspect_t'(hit_slot[1:0])) begin
          aspect_state_next[hit_slot[2]].aspect = aspect_t'(hit_slot[1:0]);
          if (aspect_t'(hit_slot[1:0]) == ASP_OFF) begin
            aspect_state_next[hit_slot[2]].pending = 1'b0;
          end else begin
            aspect_state_next[hit_slot[2]].pending = 1'b1;
            elapsed_next[hit_slot[2]]              = 8'd0;
          end
        end
      end
    end

    // A blank aspect lights once its count reaches the blanking delay.
    for (int s = 0; s < 2; s++) begin
      if (aspect_state_next[s].pending && elapsed_next[s] >= cfg.blank_secs) begin
        aspect_state_next[s].pending = 1'b0;
      end
    end

    lvl = night_mode_next ? cfg.night_level : cfg.day_level;

    // LED order per signal: Y0, Y1, G0, G1.
    for (int s = 0; s < 2; s++) begin
      for (int j = 0; j < 4; j++) begin
        leds[s][j] = 8'd0;
      end
      if (!aspect_state_next[s].pending) begin
        case (aspect_state_next[s].aspect)
          ASP_VR0: begin
            leds[s][0] = lvl;
            leds[s][1] = lvl;
          end
          ASP_VR1: begin
            leds[s][2] = lvl;
            leds[s][3] = lvl;
          end
          ASP_VR2: begin
            leds[s][1] = lvl;
            leds[s][2] = lvl;
          end
          default: ;
        endcase
      end
    end

    result.out1_level  = leds[0][0];
    result.out2_level  = leds[0][1];
    result.out3_level  = leds[0][2];
    result.out4_level  = leds[0][3];
    result.out5_level  = leds[1][3];
    result.out6_level  = leds[1][2];
    result.out7_level  = leds[1][1];
    result.out8_level  = leds[1][0];
    result.cmd_matched = matched;
  end

  // State advances only when the item is handed to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < 2; s++) begin
        aspect_state[s] <= '{aspect: ASP_VR0, pending: 1'b0};
        elapsed[s]      <= 8'd0;
      end
      last_command <= LAST_CMD_RST;
      night_mode   <= 1'b0;
    end else if (fire) begin
      aspect_state <= aspect_state_next;
      elapsed      <= elapsed_next;
      last_command <= last_command_next;
      night_mode   <= night_mode_next;
    end
  end

endmodule

>>> sim/dual_distant_signal_aspect_controller_core_tb.sv
`timescale 1ns / 100ps

module dual_distant_signal_aspect_controller_core_tb;
  import dsac_pkg::*;

  // Cycles without any transfer before the run is declared hung.
  localparam int WATCHDOG_LIMIT = 5000;
  // Settling time after the last result.
  localparam int SETTLE_CYCLES = 8;

  // Predicts the LED levels and match flag for every accepted item and
  // checks the returned results in order.
  class led_level_scoreboard;
    logic [63:0] sig_addrs [2];
    logic [31:0] mode_addrs;
    logic [7:0]  day_lvl;
    logic [7:0]  night_lvl;
    logic [7:0]  sw_delay;
    aspect_t     asp [2];
    logic        pend [2];
    logic [7:0]  secs [2];
    logic [15:0] prev_cmd;
    logic        night;
    rsp_t        expected_leds [$];
    int          n_err;

    function new();
      sig_addrs[0] = '0;
      sig_addrs[1] = '0;
      mode_addrs   = '0;
      day_lvl      = DAY_LEVEL_RST;
      night_lvl    = NIGHT_LEVEL_RST;
      sw_delay     = BLANK_SECS_RST;
      for (int s = 0; s < 2; s++) begin
        asp[s]  = ASP_VR0;
        pend[s] = 1'b0;
        secs[s] = '0;
      end
      prev_cmd = LAST_CMD_RST;
      night    = 1'b0;
      n_err    = 0;
    endfunction

    function void set_reg(logic [RegIdxW-1:0] idx, logic [63:0] value);
      case (idx)
        REG_SIG1_ADDRS:   sig_addrs[0] = value;
        REG_SIG2_ADDRS:   sig_addrs[1] = value;
        REG_MODE_ADDRS:   mode_addrs = value[31:0];
        REG_DAY_LEVEL:    day_lvl = value[7:0];
        REG_NIGHT_LEVEL:  night_lvl = value[7:0];
        REG_BLANK_SECS:   sw_delay = value[7:0];
        default: ;
      endcase
    endfunction

    // A new aspect blanks the signal and restarts its count; OFF is immediate.
    function void change_aspect(int s, aspect_t a);
      if (asp[s] == a) return;
      asp[s] = a;
      if (a == ASP_OFF) begin
        pend[s] = 1'b0;
      end else begin
        pend[s] = 1'b1;
        secs[s] = '0;
      end
    endfunction

    // Lit LEDs of one signal: bit 0 Y0, bit 1 Y1, bit 2 G0, bit 3 G1.
    function logic [3:0] lit_mask(int s);
      if (pend[s]) return 4'b0000;
      case (asp[s])
        ASP_VR0: return 4'b0011;
        ASP_VR1: return 4'b1100;
        ASP_VR2: return 4'b0110;
        default: return 4'b0000;
      endcase
    endfunction

    function void note_item(req_t it);
      rsp_t        want;
      logic        hit;
      logic [15:0] slot;
      logic [7:0]  lvl;
      logic [3:0]  m1;
      logic [3:0]  m2;
      hit = 1'b0;
      if (it.func) begin
        for (int s = 0; s < 2; s++)
          if (secs[s] != ELAPSED_MAX) secs[s] = secs[s] + 8'd1;
      end else if (it.cmd != prev_cmd) begin
        prev_cmd = it.cmd;
        if (it.cmd == mode_addrs[15:0]) begin
          night = 1'b0;
          hit   = 1'b1;
        end else if (it.cmd == mode_addrs[31:16]) begin
          night = 1'b1;
          hit   = 1'b1;
        end else begin
          // Signal one slots first, then signal two; the first hit wins.
          for (int k = 0; k < 8; k++) begin
            slot = sig_addrs[k / 4][(k % 4) * 16 +: 16];
            if (!hit && it.cmd == slot) begin
              change_aspect(k / 4, aspect_t'(k % 4));
              hit = 1'b1;
            end
          end
        end
      end

      // The blanking delay is checked after the item's own effect.
      for (int s = 0; s < 2; s++)
        if (pend[s] && secs[s] >= sw_delay) pend[s] = 1'b0;

      lvl  = night ? night_lvl : day_lvl;
      m1   = lit_mask(0);
      m2   = lit_mask(1);
      want = '0;
      want.out1_level  = m1[0] ? lvl : 8'd0;
      want.out2_level  = m1[1] ? lvl : 8'd0;
      want.out3_level  = m1[2] ? lvl : 8'd0;
      want.out4_level  = m1[3] ? lvl : 8'd0;
      want.out5_level  = m2[3] ? lvl : 8'd0;
      want.out6_level  = m2[2] ? lvl : 8'd0;
      want.out7_level  = m2[1] ? lvl : 8'd0;
      want.out8_level  = m2[0] ? lvl : 8'd0;
      want.cmd_matched = hit;
      expected_leds.push_back(want);
    endfunction

    function void compare(string field, logic [7:0] want, logic [7:0] got);
      if (got !== want) begin
        n_err++;
        if (n_err <= 10)
          $display("Mismatch on %s: expected %0d, got %0d", field, want, got);
      end
    endfunction

    function void check_leds(rsp_t got);
      rsp_t want;
      if (expected_leds.size() == 0) begin
        n_err++;
        if (n_err <= 10) $display("Result transfer with no item outstanding: %h", got);
        return;
      end
      want = expected_leds.pop_front();
      compare("out1_level", want.out1_level, got.out1_level);
      compare("out2_level", want.out2_level, got.out2_level);
      compare("out3_level", want.out3_level, got.out3_level);
      compare("out4_level", want.out4_level, got.out4_level);
      compare("out5_level", want.out5_level, got.out5_level);
      compare("out6_level", want.out6_level, got.out6_level);
      compare("out7_level", want.out7_level, got.out7_level);
      compare("out8_level", want.out8_level, got.out8_level);
      compare("cmd_matched", 8'(want.cmd_matched), 8'(got.cmd_matched));
    endfunction

    function int outstanding();
      return expected_leds.size();
    endfunction

    function int failures();
      return n_err + expected_leds.size();
    endfunction
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             req_valid = 1'b0;
  logic             req_stall;
  req_t             req = '0;
  logic             rsp_valid;
  logic             rsp_stall = 1'b0;
  rsp_t             rsp;
  logic             psel = 1'b0;
  logic             penable = 1'b0;
  logic             pwrite = 1'b0;
  logic [AddrW-1:0] paddr = '0;
  logic [DataW-1:0] pwdata = '0;
  logic [DataW-1:0] prdata;
  logic             pready;

  led_level_scoreboard sb;
  int          send_gap_pct = 0;
  int          recv_stall_pct = 0;
  int          idle_cycles = 0;
  logic [15:0] last_sent_cmd = 16'hFFFF;
  logic [63:0] cfg_sig [2];
  logic [31:0] cfg_mode;

  dual_distant_signal_aspect_controller_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready)
  );

  // 100 MHz clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Result side: check each transfer, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) sb.check_leds(rsp);
    rsp_stall <= ($urandom_range(99) < recv_stall_pct);
  end

  // Watchdog on cycles without any transfer.
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || psel) begin
      idle_cycles <= 0;
    end else if (idle_cycles == WATCHDOG_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one item, with random gaps ahead of it, and wait for the transfer.
  task automatic send_item(input req_t item);
    while ($urandom_range(99) < send_gap_pct) begin
      req_valid <= 1'b0;
      @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= item;
    @(posedge clk);
    while (req_stall) @(posedge clk);
    sb.note_item(item);
    if (!item.func) last_sent_cmd = item.cmd;
  endtask

  task automatic send_cmd(input logic [15:0] cmd);
    req_t it;
    it.func = 1'b0;
    it.cmd  = cmd;
    send_item(it);
  endtask

  // Ticks carry random junk in the command field.
  task automatic send_ticks(input int n);
    req_t it;
    repeat (n) begin
      it.func = 1'b1;
      it.cmd  = 16'($urandom());
      send_item(it);
    end
  endtask

  // Let every outstanding result come back before touching the registers.
  task automatic drain();
    req_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready.
  task automatic write_reg(input logic [RegIdxW-1:0] idx, input logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    sb.set_reg(idx, value);
  endtask

  task automatic configure(input logic [63:0] s1, input logic [63:0] s2,
                           input logic [31:0] mode, input logic [7:0] day,
                           input logic [7:0] night, input logic [7:0] dly);
    drain();
    write_reg(REG_SIG1_ADDRS, s1);
    write_reg(REG_SIG2_ADDRS, s2);
    write_reg(REG_MODE_ADDRS, 64'(mode));
    write_reg(REG_DAY_LEVEL, 64'(day));
    write_reg(REG_NIGHT_LEVEL, 64'(night));
    write_reg(REG_BLANK_SECS, 64'(dly));
    cfg_sig[0] = s1;
    cfg_sig[1] = s2;
    cfg_mode   = mode;
  endtask

  // Four address slots, each drawn from 0..top.
  function automatic logic [63:0] rand_slots(input int unsigned top);
    logic [63:0] v;
    for (int i = 0; i < 4; i++) v[i * 16 +: 16] = 16'($urandom_range(top));
    return v;
  endfunction

  // Slots 0..7 are the aspect addresses, 8 is day mode and 9 night mode.
  function automatic logic [15:0] slot_addr(input int k);
    if (k < 8) return cfg_sig[k / 4][(k % 4) * 16 +: 16];
    return (k == 8) ? cfg_mode[15:0] : cfg_mode[31:16];
  endfunction

  // Mostly configured addresses and ticks, with repeats and noise mixed in.
  task automatic run_mix(input int n, input int tick_pct);
    req_t it;
    int   r;
    repeat (n) begin
      r       = $urandom_range(99);
      it.func = 1'b0;
      it.cmd  = 16'($urandom());
      if (r < tick_pct) it.func = 1'b1;
      else if (r < tick_pct + 45) it.cmd = slot_addr($urandom_range(9));
      else if (r < tick_pct + 55) it.cmd = last_sent_cmd;
      else if (r < tick_pct + 60) it.cmd = 16'hFFFF;
      send_item(it);
    end
  endtask

  task automatic run_phase(input int p);
    case (p / 2)
      0: begin
        send_gap_pct   = 36;
        recv_stall_pct = 87;
      end
      1: begin
        send_gap_pct   = 87;
        recv_stall_pct = 36;
      end
      default: begin
        send_gap_pct   = 0;
        recv_stall_pct = 0;
      end
    endcase
    case (p)
      0: begin
        // Immediate switching, full brightness by day, dark by night.
        configure(rand_slots(16'hFFFF), rand_slots(16'hFFFF), 32'($urandom()),
                  8'd255, 8'd0, 8'd0);
        run_mix(130, 30);
      end
      1: begin
        // Tiny address space, so slots collide and priority order matters.
        configure(rand_slots(7), rand_slots(7),
                  {16'($urandom_range(7)), 16'($urandom_range(7))},
                  8'($urandom()), 8'($urandom()), 8'd1);
        run_mix(130, 30);
      end
      2: begin
        // Longest delay: force a change on both signals, then tick it out.
        configure(rand_slots(16'hFFFF), rand_slots(16'hFFFF), 32'($urandom()),
                  8'($urandom()), 8'($urandom()), 8'd255);
        run_mix(30, 30);
        send_cmd(slot_addr(0));
        send_cmd(slot_addr(1));
        send_cmd(slot_addr(6));
        send_cmd(slot_addr(5));
        send_ticks(260);
        run_mix(40, 30);
      end
      3: begin
        configure(rand_slots(16'hFFFF), rand_slots(16'hFFFF), 32'hFFFF_0000,
                  8'd0, 8'd255, 8'($urandom_range(5, 2)));
        run_mix(120, 35);
      end
      4: begin
        configure(rand_slots(7), rand_slots(7),
                  {16'($urandom_range(7)), 16'($urandom_range(7))},
                  8'($urandom()), 8'($urandom()), 8'd3);
        run_mix(130, 35);
      end
      default: begin
        configure(rand_slots(16'hFFFF), rand_slots(16'hFFFF), 32'($urandom()),
                  8'($urandom()), 8'($urandom()), 8'($urandom_range(4)));
        run_mix(120, 30);
      end
    endcase
  endtask

  initial begin
    sb          = new();
    cfg_sig[0]  = '0;
    cfg_sig[1]  = '0;
    cfg_mode    = '0;
    send_gap_pct   = 36;
    recv_stall_pct = 87;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Register defaults: 0xFFFF repeats the reset command, 0 hits day mode.
    send_cmd(16'hFFFF);
    send_ticks(1);
    send_cmd(16'h0000);

    // Directed walk through aspect changes, delay, modes and repeats.
    configure({16'h1004, 16'h1003, 16'h1002, 16'h1001},
              {16'h2004, 16'h2003, 16'h2002, 16'h2001},
              {16'h0B0B, 16'h0DA1}, 8'd200, 8'd30, 8'd2);
    send_cmd(16'h1002);
    send_cmd(16'h1002);
    send_ticks(2);
    send_cmd(16'h2003);
    send_cmd(16'h0B0B);
    send_ticks(2);
    send_cmd(16'h1004);
    send_cmd(16'h2001);
    send_cmd(16'h1234);
    send_cmd(16'h2001);
    send_ticks(2);
    send_cmd(16'h0DA1);
    send_cmd(16'h1001);
    send_cmd(16'h1003);
    send_ticks(2);
    send_cmd(16'h2004);
    send_cmd(16'h2002);
    send_cmd(16'h1004);

    for (int p = 0; p < 6; p++) run_phase(p);

    drain();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.failures() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
